@@ hdl/image_segment_partitioner_assert.svh @@
// Assertion macros for the segment partitioner
`ifndef IMAGE_SEGMENT_PARTITIONER_ASSERT_SVH
`define IMAGE_SEGMENT_PARTITIONER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ISP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ISP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/isp_pkg.sv @@
package isp_pkg;

    // fixed field widths
    localparam int DIM_W   = 16;
    localparam int OFF_W   = 32;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 6;   // segment counts up to 32
    localparam int RESULT_SLOTS = 32;

    // shared divider: dividend and divisor widths
    localparam int DIV_W   = 22;
    localparam int DSR_W   = 6;

    // job queue depth between front and back
    localparam int Q_DEPTH = 2;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // one classified job with its partition geometry
    typedef struct packed {
        logic             err;
        logic [CNT_W-1:0] s;
        logic [CNT_W-1:0] r;
        logic [CNT_W-1:0] c;
        logic [CNT_W-1:0] rt;
        logic [DIM_W-1:0] xt;
        logic [DIM_W-1:0] ct0;
        logic [DIM_W-1:0] yt;
        logic [DIM_W-1:0] rt0;
        logic [DIM_W-1:0] xb;
        logic [DIM_W-1:0] cb0;
        logic [DIM_W-1:0] yb;
        logic [DIM_W-1:0] rb0;
    } job_t;

endpackage

@@ hdl/image_segment_partitioner.sv @@
// Image segment partitioner.
// Input channel (in_valid/in_ready) carries one job: image_width, image_height
// and segment_count. Output channel (out_valid/out_ready) returns one transfer
// per segment in raster order, top region first, with last set on the final
// one; a rejected job (zero, too many, or more segments than pixels) returns a
// single transfer with status set. cfg_wr_en/cfg_wr_data load row_stride.
// In the front a job goes through a check, a row search that adds at most one
// row per step, and up to six divisions on a shared one-bit-per-cycle divider.
// Per segment the back does the offset multiply, then the output load.
// A 2-entry job queue lets the front work on the next job as the back emits.
// in_ready is high only while the front is free. When the receiver stalls,
// the output register holds and the back stalls; the queue then fills and
// the front blocks on it. Reset clears all control state, empties the
// queue and sets row_stride to zero.
module image_segment_partitioner #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [isp_pkg::DIM_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [isp_pkg::DIM_W-1:0] image_width,
    input  logic [isp_pkg::DIM_W-1:0] image_height,
    input  logic [isp_pkg::DIM_W-1:0] segment_count,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      status,
    output logic [isp_pkg::IDX_W-1:0] segment_index,
    output logic [isp_pkg::DIM_W-1:0] row_start,
    output logic [isp_pkg::DIM_W-1:0] col_start,
    output logic [isp_pkg::DIM_W-1:0] seg_width,
    output logic [isp_pkg::DIM_W-1:0] seg_height,
    output logic [isp_pkg::OFF_W-1:0] start_offset,
    output logic                      bottom_region,
    output logic                      last
);
    import isp_pkg::*;

`include "image_segment_partitioner_assert.svh"

    logic [DIM_W-1:0] row_stride_reg;
    logic             fj_valid, fj_ready;
    job_t             fj_data;
    logic             bj_valid, bj_ready;
    job_t             bj_data;

    // stride register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_stride_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            row_stride_reg <= cfg_wr_data;
        end
    end

    isp_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .image_width   (image_width),
        .image_height  (image_height),
        .segment_count (segment_count),
        .job_valid     (fj_valid),
        .job_ready     (fj_ready),
        .job           (fj_data)
    );

    isp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj_data),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_data  (bj_data)
    );

    isp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_stride    (row_stride_reg),
        .job_valid     (bj_valid),
        .job_ready     (bj_ready),
        .job           (bj_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .segment_index (segment_index),
        .row_start     (row_start),
        .col_start     (col_start),
        .seg_width     (seg_width),
        .seg_height    (seg_height),
        .start_offset  (start_offset),
        .bottom_region (bottom_region),
        .last          (last)
    );

    // error results are single and final
    `ISP_ASSERT_IMP(a_err_last, out_valid && status, last, "error result without last")
    `ISP_ASSERT_IMP(a_err_idx, out_valid && status, segment_index == '0,
                    "error result with nonzero index")
    // the front is busy right after taking a job
    `ISP_ASSERT_NXT(a_front_busy, in_valid && in_ready, !in_ready,
                    "front ready again right after a transfer")

endmodule

@@ hdl/isp_div.sv @@
module isp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [isp_pkg::DIV_W-1:0]  dividend,
    input  logic [isp_pkg::DSR_W-1:0]  divisor,
    output logic                       done,
    output logic [isp_pkg::DIV_W-1:0]  quotient
);
    import isp_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_W + 1);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0]    dsr_reg, dsr_next;
    logic [DSR_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DSR_W:0]      shifted;
    logic [DSR_W:0]      diff;
    logic                ge;

    // one restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        ge        = shifted >= {1'b0, dsr_reg};
        diff      = shifted - {1'b0, dsr_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_BITS'(DIV_W);
            dsr_next = divisor;
            rem_next = '0;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/isp_front.sv @@
module isp_front #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [isp_pkg::DIM_W-1:0] image_width,
    input  logic [isp_pkg::DIM_W-1:0] image_height,
    input  logic [isp_pkg::DIM_W-1:0] segment_count,
    output logic                      job_valid,
    input  logic                      job_ready,
    output isp_pkg::job_t             job
);
    import isp_pkg::*;

    localparam int SEG_LIMIT = (MAX_SEGMENTS < RESULT_SLOTS) ? MAX_SEGMENTS : RESULT_SLOTS;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CHK  = 5'd1;
    localparam logic [4:0] ST_PRE  = 5'd2;
    localparam logic [4:0] ST_SRCH = 5'd3;
    localparam logic [4:0] ST_DC   = 5'd4;
    localparam logic [4:0] ST_DCW  = 5'd5;
    localparam logic [4:0] ST_RT   = 5'd6;
    localparam logic [4:0] ST_CR   = 5'd7;
    localparam logic [4:0] ST_NUM  = 5'd8;
    localparam logic [4:0] ST_DQ   = 5'd9;
    localparam logic [4:0] ST_DQW  = 5'd10;
    localparam logic [4:0] ST_DX   = 5'd11;
    localparam logic [4:0] ST_DXW  = 5'd12;
    localparam logic [4:0] ST_DY   = 5'd13;
    localparam logic [4:0] ST_DYW  = 5'd14;
    localparam logic [4:0] ST_DXB  = 5'd15;
    localparam logic [4:0] ST_DXBW = 5'd16;
    localparam logic [4:0] ST_DYB  = 5'd17;
    localparam logic [4:0] ST_DYBW = 5'd18;
    localparam logic [4:0] ST_PUSH = 5'd19;

    logic [4:0]       state_reg, state_next;
    job_t             job_reg, job_next;
    logic [DIM_W-1:0] w_reg, w_next;
    logic [DIM_W-1:0] h_reg, h_next;
    logic [DIM_W-1:0] s_reg, s_next;
    logic [10:0]      rr_reg, rr_next;
    logic [21:0]      hs_reg, hs_next;
    logic [10:0]      cr_reg, cr_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DIM_W-1:0] ht_reg, ht_next;
    logic [DIM_W-1:0] hb_reg, hb_next;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] quo;

    logic [31:0] wh;
    logic [21:0] sm1w;
    logic [26:0] rrw;
    logic [11:0] rtf;
    logic [27:0] hcr;
    logic [28:0] numf;
    logic [23:0] fix;
    logic [CNT_W-1:0] rb_rows;

    isp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign rb_rows = job_reg.r - job_reg.rt;

    // geometry sequencer
    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        s_next       = s_reg;
        rr_next      = rr_reg;
        hs_next      = hs_reg;
        cr_next      = cr_reg;
        num_next     = num_reg;
        ht_next      = ht_reg;
        hb_next      = hb_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        wh   = 32'(w_reg) * 32'(h_reg);
        sm1w = 22'(job_reg.s - CNT_W'(1)) * 22'(w_reg);
        rrw  = 27'(rr_reg) * 27'(w_reg);
        rtf  = (12'(job_reg.c) + 12'd1) * 12'(job_reg.r) - 12'(job_reg.s);
        hcr  = 28'(h_reg) * 28'(cr_reg);
        numf = {hcr, 1'b0} + 29'(job_reg.s);
        fix  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    w_next     = image_width;
                    h_next     = image_height;
                    s_next     = segment_count;
                    state_next = ST_CHK;
                end
            end
            // reject zero, too many, or more than pixels
            ST_CHK:
            begin
                job_next.s = s_reg[CNT_W-1:0];
                if (s_reg == '0 || s_reg > DIM_W'(SEG_LIMIT) || {16'b0, s_reg} > wh)
                begin
                    job_next.err = 1'b1;
                    state_next   = ST_PUSH;
                end
                else
                begin
                    job_next.err = 1'b0;
                    state_next   = ST_PRE;
                end
            end
            ST_PRE:
            begin
                hs_next = 22'(h_reg) * 22'(job_reg.s);
                if ({6'b0, h_reg} > sm1w)
                begin
                    job_next.r = job_reg.s;
                    state_next = ST_DC;
                end
                else
                begin
                    job_next.r = CNT_W'(1);
                    rr_next    = 11'd2;
                    state_next = ST_SRCH;
                end
            end
            // row count search, rr holds r*(r+1)
            ST_SRCH:
            begin
                if (job_reg.r < job_reg.s && rrw < {5'b0, hs_reg})
                begin
                    job_next.r = job_reg.r + CNT_W'(1);
                    rr_next    = rr_reg + {4'b0, job_reg.r + CNT_W'(1), 1'b0};
                end
                else
                begin
                    state_next = ST_DC;
                end
            end
            ST_DC:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(job_reg.s);
                div_divisor  = job_reg.r;
                state_next   = ST_DCW;
            end
            ST_DCW:
            begin
                if (div_done)
                begin
                    job_next.c = quo[CNT_W-1:0];
                    state_next = ST_RT;
                end
            end
            ST_RT:
            begin
                job_next.rt = rtf[CNT_W-1:0];
                state_next  = ST_CR;
            end
            ST_CR:
            begin
                cr_next    = 11'(job_reg.c) * 11'(job_reg.rt);
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                num_next   = numf[DIV_W:1];
                state_next = ST_DQ;
            end
            // top region height
            ST_DQ:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                div_divisor  = job_reg.s;
                state_next   = ST_DQW;
            end
            ST_DQW:
            begin
                if (div_done)
                begin
                    ht_next    = (quo > DIV_W'(job_reg.rt)) ? quo[DIM_W-1:0]
                                                            : DIM_W'(job_reg.rt);
                    state_next = ST_DX;
                end
            end
            ST_DX:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(w_reg);
                div_divisor  = job_reg.c;
                state_next   = ST_DXW;
            end
            ST_DXW:
            begin
                fix = 24'(17'(quo[DIM_W-1:0]) + 17'd1) * 24'(job_reg.c) - 24'(w_reg);
                if (div_done)
                begin
                    job_next.xt  = quo[DIM_W-1:0];
                    job_next.ct0 = fix[DIM_W-1:0];
                    state_next   = ST_DY;
                end
            end
            ST_DY:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(ht_reg);
                div_divisor  = job_reg.rt;
                state_next   = ST_DYW;
            end
            ST_DYW:
            begin
                fix = 24'(17'(quo[DIM_W-1:0]) + 17'd1) * 24'(job_reg.rt) - 24'(ht_reg);
                if (div_done)
                begin
                    job_next.yt  = quo[DIM_W-1:0];
                    job_next.rt0 = fix[DIM_W-1:0];
                    if (job_reg.rt < job_reg.r)
                    begin
                        state_next = ST_DXB;
                    end
                    else
                    begin
                        job_next.xb  = '0;
                        job_next.cb0 = '0;
                        job_next.yb  = '0;
                        job_next.rb0 = '0;
                        state_next   = ST_PUSH;
                    end
                end
            end
            // bottom region, one extra column
            ST_DXB:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(w_reg);
                div_divisor  = job_reg.c + CNT_W'(1);
                hb_next      = (h_reg > ht_reg) ? h_reg - ht_reg : '0;
                state_next   = ST_DXBW;
            end
            ST_DXBW:
            begin
                fix = 24'(17'(quo[DIM_W-1:0]) + 17'd1) * (24'(job_reg.c) + 24'd1)
                      - 24'(w_reg);
                if (div_done)
                begin
                    job_next.xb  = quo[DIM_W-1:0];
                    job_next.cb0 = fix[DIM_W-1:0];
                    state_next   = ST_DYB;
                end
            end
            ST_DYB:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(hb_reg);
                div_divisor  = rb_rows;
                state_next   = ST_DYBW;
            end
            ST_DYBW:
            begin
                fix = 24'(17'(quo[DIM_W-1:0]) + 17'd1) * 24'(rb_rows) - 24'(hb_reg);
                if (div_done)
                begin
                    job_next.yb  = quo[DIM_W-1:0];
                    job_next.rb0 = fix[DIM_W-1:0];
                    state_next   = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        w_reg   <= w_next;
        h_reg   <= h_next;
        s_reg   <= s_next;
        rr_reg  <= rr_next;
        hs_reg  <= hs_next;
        cr_reg  <= cr_next;
        num_reg <= num_next;
        ht_reg  <= ht_next;
        hb_reg  <= hb_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign job_valid = (state_reg == ST_PUSH);
    assign job       = job_reg;

endmodule

@@ hdl/isp_fifo.sv @@
module isp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  isp_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output isp_pkg::job_t rd_data
);
    import isp_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CT_W  = $clog2(Q_DEPTH + 1);

    job_t             mem [Q_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CT_W-1:0]  cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CT_W'(Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/isp_back.sv @@
module isp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [isp_pkg::DIM_W-1:0] row_stride,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  isp_pkg::job_t             job,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      status,
    output logic [isp_pkg::IDX_W-1:0] segment_index,
    output logic [isp_pkg::DIM_W-1:0] row_start,
    output logic [isp_pkg::DIM_W-1:0] col_start,
    output logic [isp_pkg::DIM_W-1:0] seg_width,
    output logic [isp_pkg::DIM_W-1:0] seg_height,
    output logic [isp_pkg::OFF_W-1:0] start_offset,
    output logic                      bottom_region,
    output logic                      last
);
    import isp_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_ERR  = 2'd1;
    localparam logic [1:0] B_MUL  = 2'd2;
    localparam logic [1:0] B_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    job_t             job_reg, job_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             bot_reg, bot_next;
    logic [DIM_W-1:0] prow_reg, prow_next;
    logic [DIM_W-1:0] pcol_reg, pcol_next;
    logic [OFF_W-1:0] prod_reg, prod_next;

    logic             ov_reg, ov_next;
    logic             st_reg, st_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [DIM_W-1:0] rs_reg, rs_next;
    logic [DIM_W-1:0] cs_reg, cs_next;
    logic [DIM_W-1:0] sw_reg, sw_next;
    logic [DIM_W-1:0] sh_reg, sh_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             bo_reg, bo_next;
    logic             last_reg, last_next;

    logic             slot_free;
    logic [DIM_W-1:0] xw, cz, yh, rz, sw, sh;
    logic [CNT_W:0]   nrows, ncols;
    logic             is_last;

    assign slot_free = !ov_reg || out_ready;

    // region selection for the current walk position
    always_comb
    begin
        xw    = bot_reg ? job_reg.xb  : job_reg.xt;
        cz    = bot_reg ? job_reg.cb0 : job_reg.ct0;
        yh    = bot_reg ? job_reg.yb  : job_reg.yt;
        rz    = bot_reg ? job_reg.rb0 : job_reg.rt0;
        nrows = bot_reg ? (CNT_W+1)'(job_reg.r - job_reg.rt) : (CNT_W+1)'(job_reg.rt);
        ncols = (CNT_W+1)'(job_reg.c) + (CNT_W+1)'(bot_reg);
        sw    = xw + DIM_W'(DIM_W'(j_reg) >= cz);
        sh    = yh + DIM_W'(DIM_W'(i_reg) >= rz);
        is_last = ((CNT_W+1)'(n_reg) + (CNT_W+1)'(1)) == (CNT_W+1)'(job_reg.s);
    end

    // segment walker
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        bot_next   = bot_reg;
        prow_next  = prow_reg;
        pcol_next  = pcol_reg;
        prod_next  = prod_reg;
        ov_next    = ov_reg && !out_ready;
        st_next    = st_reg;
        idx_next   = idx_reg;
        rs_next    = rs_reg;
        cs_next    = cs_reg;
        sw_next    = sw_reg;
        sh_next    = sh_reg;
        off_next   = off_reg;
        bo_next    = bo_reg;
        last_next  = last_reg;
        job_ready  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    job_next   = job;
                    i_next     = '0;
                    j_next     = '0;
                    n_next     = '0;
                    bot_next   = 1'b0;
                    prow_next  = '0;
                    pcol_next  = '0;
                    state_next = job.err ? B_ERR : B_MUL;
                end
            end
            B_ERR:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    st_next    = STATUS_ERR;
                    idx_next   = '0;
                    rs_next    = '0;
                    cs_next    = '0;
                    sw_next    = '0;
                    sh_next    = '0;
                    off_next   = '0;
                    bo_next    = 1'b0;
                    last_next  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_MUL:
            begin
                prod_next  = OFF_W'(prow_reg) * OFF_W'(row_stride);
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    st_next   = STATUS_OK;
                    idx_next  = n_reg[IDX_W-1:0];
                    rs_next   = prow_reg;
                    cs_next   = pcol_reg;
                    sw_next   = sw;
                    sh_next   = sh;
                    off_next  = prod_reg + OFF_W'(pcol_reg);
                    bo_next   = bot_reg;
                    last_next = is_last;
                    n_next    = n_reg + CNT_W'(1);
                    // step along the row, then down, then into the bottom region
                    if ((CNT_W+1)'(j_reg) + (CNT_W+1)'(1) == ncols)
                    begin
                        j_next    = '0;
                        pcol_next = '0;
                        prow_next = prow_reg + sh;
                        if ((CNT_W+1)'(i_reg) + (CNT_W+1)'(1) == nrows)
                        begin
                            i_next   = '0;
                            bot_next = 1'b1;
                        end
                        else
                        begin
                            i_next = i_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        j_next    = j_reg + CNT_W'(1);
                        pcol_next = pcol_reg + sw;
                    end
                    state_next = is_last ? B_IDLE : B_MUL;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        n_reg    <= n_next;
        bot_reg  <= bot_next;
        prow_reg <= prow_next;
        pcol_reg <= pcol_next;
        prod_reg <= prod_next;
        st_reg   <= st_next;
        idx_reg  <= idx_next;
        rs_reg   <= rs_next;
        cs_reg   <= cs_next;
        sw_reg   <= sw_next;
        sh_reg   <= sh_next;
        off_reg  <= off_next;
        bo_reg   <= bo_next;
        last_reg <= last_next;
    end

    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign segment_index = idx_reg;
    assign row_start     = rs_reg;
    assign col_start     = cs_reg;
    assign seg_width     = sw_reg;
    assign seg_height    = sh_reg;
    assign start_offset  = off_reg;
    assign bottom_region = bo_reg;
    assign last          = last_reg;

endmodule
